// ===== hdl/lpfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpfr_pkg
// shared types and constants of the length-prefixed frame receiver
// ----------------------------------------------------------------------------
package lpfr_pkg;

    localparam int unsigned BYTE_W = 8;

    // checksum byte is the inverted 8-bit sum of all earlier frame bytes
    localparam logic [BYTE_W-1:0] CHECK_INVERT = 8'hFF;
    // shortest legal frame: length, type and checksum bytes
    localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd3;
    // frame positions of the length and type bytes
    localparam logic [BYTE_W-1:0] POS_LENGTH = 8'd0;
    localparam logic [BYTE_W-1:0] POS_TYPE = 8'd1;
    // bytes ahead of the payload
    localparam logic [BYTE_W-1:0] HEADER_LEN = 8'd2;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_GOOD    = 2'd1,
        EV_BAD_SUM = 2'd2,
        EV_BAD_LEN = 2'd3
    } lpfr_event_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_len;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] frame_type;
        lpfr_event_t       event_res;
    } lpfr_result_t;

endpackage : lpfr_pkg
`default_nettype wire

// ===== hdl/lpfr_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpfr_parser
// frame state tracking and event decode for one received byte
// ----------------------------------------------------------------------------
module lpfr_parser (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   step,      // byte consumed this cycle
    input  wire logic [7:0]             rx_byte,
    output logic                        res_valid, // byte produces an event
    output lpfr_pkg::lpfr_result_t      res
);
    import lpfr_pkg::*;

    logic [BYTE_W-1:0] position_reg, position_next;
    logic [BYTE_W-1:0] frame_length_reg, frame_length_next;
    logic [BYTE_W-1:0] running_sum_reg, running_sum_next;
    logic [BYTE_W-1:0] held_type_reg, held_type_next;

    logic [BYTE_W-1:0] plen;
    logic [BYTE_W:0]   pos_plus_one;

    assign plen         = frame_length_reg - MIN_FRAME_LEN;
    assign pos_plus_one = {1'b0, position_reg} + {{BYTE_W{1'b0}}, 1'b1};

    always_comb begin
        position_next     = position_reg;
        frame_length_next = frame_length_reg;
        running_sum_next  = running_sum_reg;
        held_type_next    = held_type_reg;
        res_valid         = 1'b0;
        res.event_res     = EV_PAYLOAD;
        res.frame_type    = '0;
        res.data_byte     = '0;
        res.byte_index    = '0;
        res.payload_len   = '0;

        priority if (position_reg == POS_LENGTH) begin
            if (rx_byte < MIN_FRAME_LEN) begin
                res_valid     = 1'b1;
                res.event_res = EV_BAD_LEN;
            end else begin
                frame_length_next = rx_byte;
                running_sum_next  = rx_byte;
                position_next     = POS_TYPE;
            end
        end else if (position_reg == POS_TYPE) begin
            held_type_next   = rx_byte;
            running_sum_next = running_sum_reg + rx_byte;
            position_next    = HEADER_LEN;
        end else if (pos_plus_one < {1'b0, frame_length_reg}) begin
            // payload byte
            res_valid        = 1'b1;
            res.event_res    = EV_PAYLOAD;
            res.frame_type   = held_type_reg;
            res.data_byte    = rx_byte;
            res.byte_index   = position_reg - HEADER_LEN;
            res.payload_len  = plen;
            running_sum_next = running_sum_reg + rx_byte;
            position_next    = pos_plus_one[BYTE_W-1:0];
        end else begin
            // checksum byte closes the frame
            res_valid       = 1'b1;
            res.event_res   = (rx_byte == (running_sum_reg ^ CHECK_INVERT)) ?
                              EV_GOOD : EV_BAD_SUM;
            res.frame_type  = held_type_reg;
            res.payload_len = plen;
            position_next     = '0;
            frame_length_next = '0;
            running_sum_next  = '0;
            held_type_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg     <= '0;
            frame_length_reg <= '0;
            running_sum_reg  <= '0;
            held_type_reg    <= '0;
        end else if (step) begin
            position_reg     <= position_next;
            frame_length_reg <= frame_length_next;
            running_sum_reg  <= running_sum_next;
            held_type_reg    <= held_type_next;
        end
    end

endmodule : lpfr_parser
`default_nettype wire

// ===== hdl/length_prefixed_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// byte-stream receiver for length-prefixed frames with inverted-sum checksum
// ----------------------------------------------------------------------------
// Takes one received byte per transfer on the s_ side. A frame is a length
// byte (whole frame length, itself and checksum included), a type byte, the
// payload, and a checksum byte equal to the 8-bit sum of all earlier bytes
// xor 0xff. Each payload byte leaves as one m_ transfer with its index; the
// checksum byte gives one frame-good or bad-checksum event, after which the
// receiver waits for the next length byte. A length below three gives a
// bad-length event at once. Length and type bytes give no transfer. One byte
// is taken every cycle unless s_tready is held low: it passes an input
// register, the frame decode, and an output register that drives m_tvalid.
// Both registers advance together whenever the output
// register is empty or being taken; a waiting result holds back a new byte
// only once the input register also holds a byte.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] frame_type, [15:8] data_byte,
                                        // [23:16] byte_index, [31:24] payload_len
    output logic [1:0]       m_tuser    // [1:0] event_res
);
    import lpfr_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // output register
    logic              out_valid_reg;
    lpfr_result_t      out_res_reg;

    // decode result of the held byte
    logic              res_valid;
    lpfr_result_t      res;

    // pipeline moves when the output slot is free or being emptied
    logic              advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // byte payload only loads on a transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // frame state steps once per consumed byte
    lpfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_valid_reg && advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.payload_len, out_res_reg.byte_index,
                       out_res_reg.data_byte, out_res_reg.frame_type};
    assign m_tuser  = out_res_reg.event_res;

endmodule : length_prefixed_frame_receiver
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the length-prefixed frame receiver
// ----------------------------------------------------------------------------
// Feeds the receiver a directed table of frames first: the short lengths, the
// shortest legal frame with a good and a bad checksum, and small payload
// frames. Random traffic follows: mostly well-formed frames of random length,
// type and payload, some with a broken checksum, mixed with short-length
// bytes and stray bytes that knock the framing off. Every accepted byte
// steps a behavioral frame decoder kept in the bench; each m_ transfer is
// compared field by field against the oldest outstanding prediction. The run
// walks through several sender/receiver throttling mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import lpfr_pkg::*;

    localparam int CLK_HALF_NS       = 5;
    localparam int RESET_CYCLES      = 2;
    localparam int ITEMS_PER_PHASE   = 450;
    localparam int NUM_PHASES        = 4;
    // two-stage pipeline plus margin
    localparam int DRAIN_CYCLES      = 8;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int MAX_REPORTS       = 10;

    // how a directed row is checked
    typedef enum logic [1:0] {
        ROW_PREDICT,    // expectation comes from the frame decoder
        ROW_QUIET,      // byte must give no transfer
        ROW_RESULT      // expectation is typed into the table
    } row_kind_t;

    typedef struct {
        logic [7:0]   rx_byte;
        row_kind_t    kind;
        lpfr_result_t res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [7:0] frame_type, [15:8] data_byte,
                            // [23:16] byte_index, [31:24] payload_len
    logic [1:0]  m_tuser;   // [1:0] event_res

    length_prefixed_frame_receiver dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // decoder state, mirrors the receiver's frame tracking
    logic [7:0] frm_pos;
    logic [7:0] frm_len;
    logic [7:0] frm_sum;
    logic [7:0] frm_type;

    lpfr_result_t pending_results[$];
    stim_row_t    dir_rows[19];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned items_sent;
    int unsigned fail_count;
    int unsigned quiet_cycles;

    lpfr_result_t got_res;
    lpfr_result_t want_res;

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF_NS aclk = ~aclk;
    end

    function automatic lpfr_result_t res_of(input lpfr_event_t ev, input logic [7:0] ftype,
                                            input logic [7:0] data, input logic [7:0] idx,
                                            input logic [7:0] plen);
        lpfr_result_t r;
        r.event_res   = ev;
        r.frame_type  = ftype;
        r.data_byte   = data;
        r.byte_index  = idx;
        r.payload_len = plen;
        return r;
    endfunction

    function automatic string res_text(input lpfr_result_t r);
        return $sformatf("ev=%0d type=%h data=%h idx=%0d plen=%0d", r.event_res,
                         r.frame_type, r.data_byte, r.byte_index, r.payload_len);
    endfunction

    function void clear_frame();
        frm_pos  = POS_LENGTH;
        frm_len  = '0;
        frm_sum  = '0;
        frm_type = '0;
    endfunction

    // steps the decoder by one byte; returns 1 when the byte gives a transfer
    function bit frame_decode(input logic [7:0] b, output lpfr_result_t r);
        logic [7:0]  plen;
        lpfr_event_t ev;
        r = '0;
        if (frm_pos == POS_LENGTH) begin
            // too short to hold type and checksum: flagged and dropped
            if (b < MIN_FRAME_LEN) begin
                r = res_of(EV_BAD_LEN, 8'h00, 8'h00, 8'h00, 8'h00);
                clear_frame();
                return 1'b1;
            end
            frm_len = b;
            frm_sum = b;
            frm_pos = POS_TYPE;
            return 1'b0;
        end
        if (frm_pos == POS_TYPE) begin
            frm_type = b;
            frm_sum  = frm_sum + b;
            frm_pos  = HEADER_LEN;
            return 1'b0;
        end
        plen = frm_len - MIN_FRAME_LEN;
        // every position short of the last one carries payload
        if ({1'b0, frm_pos} + 9'd1 < {1'b0, frm_len}) begin
            r = res_of(EV_PAYLOAD, frm_type, b, frm_pos - HEADER_LEN, plen);
            frm_sum = frm_sum + b;
            frm_pos = frm_pos + 8'd1;
            return 1'b1;
        end
        // checksum byte closes the frame either way
        ev = (b == (frm_sum ^ CHECK_INVERT)) ? EV_GOOD : EV_BAD_SUM;
        r = res_of(ev, frm_type, 8'h00, 8'h00, plen);
        clear_frame();
        return 1'b1;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
        fail_count++;
    endtask

    // one byte transfer on the s_ side, then queue what it should cause
    task automatic send_byte(input logic [7:0] b, input row_kind_t kind = ROW_PREDICT,
                             input lpfr_result_t typed_res = '0);
        lpfr_result_t predicted;
        bit           produces;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        produces = frame_decode(b, predicted);
        case (kind)
            ROW_PREDICT: begin
                if (produces)
                    pending_results = {pending_results, predicted};
            end
            ROW_RESULT: begin
                pending_results = {pending_results, typed_res};
            end
            default: begin
            end
        endcase
    endtask

    // whole frame with random type and payload; checksum good or broken
    task automatic send_frame(input int unsigned flen, input bit good_sum);
        logic [7:0] sum;
        logic [7:0] b;
        sum = flen[7:0];
        send_byte(flen[7:0]);
        b = 8'($urandom);
        sum = sum + b;
        send_byte(b);
        for (int unsigned i = MIN_FRAME_LEN; i < flen; i++) begin
            b = 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        // a nonzero flip guarantees the broken checksum is really wrong
        if (good_sum)
            send_byte(sum ^ CHECK_INVERT);
        else
            send_byte(sum ^ CHECK_INVERT ^ 8'($urandom_range(1, 255)));
    endtask

    // receiver side: random backpressure and result checking
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got_res.frame_type  = m_tdata[7:0];
            got_res.data_byte   = m_tdata[15:8];
            got_res.byte_index  = m_tdata[23:16];
            got_res.payload_len = m_tdata[31:24];
            got_res.event_res   = lpfr_event_t'(m_tuser);
            if (pending_results.size() == 0) begin
                note_failure({"unexpected transfer: ", res_text(got_res)});
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.event_res !== want_res.event_res
                        || got_res.frame_type !== want_res.frame_type
                        || got_res.data_byte !== want_res.data_byte
                        || got_res.byte_index !== want_res.byte_index
                        || got_res.payload_len !== want_res.payload_len)
                    note_failure({"expected ", res_text(want_res),
                                  " got ", res_text(got_res)});
            end
        end
    end

    // cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("length_prefixed_frame_receiver: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int unsigned phase_idle[NUM_PHASES];
        int unsigned phase_stall[NUM_PHASES];
        int unsigned phase_end;
        int unsigned pick;
        int unsigned flen;

        phase_idle  = '{0, 55, 0, 17};
        phase_stall = '{0, 0, 55, 17};
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        fail_count     = 0;
        quiet_cycles   = 0;
        clear_frame();

        dir_rows = '{
            // lengths too short for a frame
            '{8'h00, ROW_RESULT, res_of(EV_BAD_LEN, 8'h00, 8'h00, 8'h00, 8'h00)},
            '{8'h01, ROW_RESULT, res_of(EV_BAD_LEN, 8'h00, 8'h00, 8'h00, 8'h00)},
            '{8'h02, ROW_RESULT, res_of(EV_BAD_LEN, 8'h00, 8'h00, 8'h00, 8'h00)},
            // shortest frame, good checksum, all-ones type
            '{8'h03, ROW_QUIET,  '0},
            '{8'hFF, ROW_QUIET,  '0},
            '{8'hFD, ROW_RESULT, res_of(EV_GOOD, 8'hFF, 8'h00, 8'h00, 8'h00)},
            // shortest frame, bad checksum, zero type
            '{8'h03, ROW_QUIET,  '0},
            '{8'h00, ROW_QUIET,  '0},
            '{8'h00, ROW_RESULT, res_of(EV_BAD_SUM, 8'h00, 8'h00, 8'h00, 8'h00)},
            // three payload bytes at the data extremes, good checksum
            '{8'h06, ROW_QUIET,  '0},
            '{8'hA5, ROW_QUIET,  '0},
            '{8'h00, ROW_PREDICT, '0},
            '{8'hFF, ROW_PREDICT, '0},
            '{8'h80, ROW_PREDICT, '0},
            '{8'hD5, ROW_PREDICT, '0},
            // one payload byte, checksum off
            '{8'h04, ROW_QUIET,  '0},
            '{8'h5A, ROW_QUIET,  '0},
            '{8'h7F, ROW_PREDICT, '0},
            '{8'hFF, ROW_PREDICT, '0}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].rx_byte, dir_rows[i].kind, dir_rows[i].res);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            send_idle_pct  = phase_idle[phase];
            recv_stall_pct = phase_stall[phase];
            phase_end = items_sent + ITEMS_PER_PHASE;
            // longest frame once, at full speed
            if (phase == 0)
                send_frame(255, 1'b1);
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    send_byte(8'($urandom_range(0, 2)));
                end else if (pick < 14) begin
                    // stray byte, framing resyncs on its own
                    send_byte(8'($urandom));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        flen = $urandom_range(3, 12);
                    else if (pick < 97)
                        flen = $urandom_range(13, 48);
                    else
                        flen = $urandom_range(200, 255);
                    send_frame(flen, $urandom_range(0, 3) != 0);
                end
            end
            // sender holds off until the receiver has delivered everything
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge aclk);
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end

        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));

        if (fail_count == 0)
            $display("length_prefixed_frame_receiver: match");
        else
            $display("length_prefixed_frame_receiver: mismatch");
        $finish;
    end

endmodule : tb_top
